>>> rtl/ppu_pkg.sv
// Shared types and constants for the packed pixel palette unpacker.
`timescale 1ns / 1ps
package ppu_pkg;

  localparam int unsigned XY_W       = 12;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned SLOT_MAX   = 8;
  localparam int unsigned OFIFO_DEPTH = 3;

  localparam int unsigned CFG_MODE_W   = 3;
  localparam int unsigned CFG_DIM_W    = 13;
  localparam int unsigned CFG_STRIDE_W = 14;
  localparam int unsigned CFG_IDX_W    = 2;

  typedef enum logic [1:0] {
    REQ_PAL_WRITE = 2'd0,
    REQ_RASTER    = 2'd1,
    REQ_RESTART   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    MODE_1BPP  = 3'd0,
    MODE_2BPP  = 3'd1,
    MODE_4BPP  = 3'd2,
    MODE_8BPP  = 3'd3,
    MODE_24BPP = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_MODE = 2'd0,
    CFG_WIDTH      = 2'd1,
    CFG_HEIGHT     = 2'd2,
    CFG_STRIDE     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_MODE_W-1:0]   mode;
    logic [CFG_DIM_W-1:0]    width;
    logic [CFG_DIM_W-1:0]    height;
    logic [CFG_STRIDE_W-1:0] stride;
  } cfg_t;

  // Palette write from the request side to the palette memory.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
  } pal_wr_t;

  // One pixel slot leaving the issue stage.
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic               direct;
    logic [COLOR_W-1:0] rgb;
    logic [XY_W-1:0]    x;
    logic [XY_W-1:0]    y;
    logic               last;
    logic               done;
  } iss_t;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            last;
    logic            done;
  } pix_t;

endpackage

>>> rtl/ppu_if.sv
// Handshake channel interfaces: request words, pixel words, register writes.
`timescale 1ns / 1ps
interface ppu_req_if import ppu_pkg::*; ();
  logic               valid;
  logic               ready;
  req_e               req_type;
  logic [IDX_W-1:0]   palette_index;
  logic [COLOR_W-1:0] palette_color;
  logic [7:0]         data_byte;

  modport source (output valid, req_type, palette_index, palette_color, data_byte,
                  input ready);
  modport sink   (input valid, req_type, palette_index, palette_color, data_byte,
                  output ready);
endinterface

interface ppu_pix_if import ppu_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [XY_W-1:0] pixel_x;
  logic [XY_W-1:0] pixel_y;
  logic [7:0]      red;
  logic [7:0]      green;
  logic [7:0]      blue;
  logic            last_of_item;
  logic            image_done;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, last_of_item,
                  image_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, last_of_item,
                  image_done, output ready);
endinterface

interface ppu_cfg_if import ppu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_W-1:0]    idx;
  logic [CFG_STRIDE_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

>>> rtl/ppu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ppu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ppu_scan.sv
// Request intake, raster position counters and the per-slot pixel issuer.
`timescale 1ns / 1ps
module ppu_scan import ppu_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppu_req_if.sink   req_i,
  input  cfg_t      cfg_i,
  input  logic      room_i,
  output pal_wr_t   pal_wr_o,
  output iss_t      iss_o
);

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW   = WW + 1;
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned BW   = $clog2(3 * MAX_WIDTH + 16384);
  localparam int unsigned PW   = WW + 5;
  localparam int unsigned WCMP = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
  localparam int unsigned HCMP = (HW > CFG_DIM_W) ? HW : CFG_DIM_W;

  // Effective geometry
  logic [WCMP-1:0] w_ext;
  logic [HCMP-1:0] h_ext;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  mode_e           mode_eff;
  logic [3:0]      slots;
  logic [PW-1:0]   w_pw;
  logic [PW-1:0]   row_bits;
  logic [BW-1:0]   packed_len;
  logic [BW-1:0]   stride_ext;
  logic [BW-1:0]   stride_eff;

  // Raster position
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [BW-1:0] byte_q, byte_d;
  logic [1:0]    phase_q, phase_d;
  logic [15:0]   part_q, part_d;

  // Issuer
  logic [3:0]         rem_q, rem_d;
  logic [WW-1:0]      ix_q, ix_d;
  logic [RW-1:0]      iy_q, iy_d;
  logic [7:0]         dat_q, dat_d;
  mode_e              imode_q, imode_d;
  logic               dir_q, dir_d;
  logic [COLOR_W-1:0] rgb_q, rgb_d;

  logic          acc;
  logic          issue;
  logic [3:0]    col_inc;
  logic [CW:0]   col_sum;
  logic [CW-1:0] w_left;
  logic [3:0]    n_pix;
  logic [BW-1:0] byte_nx;
  logic [HW-1:0] row_nx;
  logic [IDX_W-1:0] slot_idx;

  always_comb begin
    w_ext = WCMP'(cfg_i.width);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_ext);
    end
    h_ext = HCMP'(cfg_i.height);
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_ext);
    end
  end

  // Undefined mode codes fall back to 8 bit indexed
  always_comb begin
    w_pw = PW'(w_eff);
    case (cfg_i.mode)
      MODE_1BPP: begin
        mode_eff = MODE_1BPP;  slots = 4'd8; row_bits = w_pw;
      end
      MODE_2BPP: begin
        mode_eff = MODE_2BPP;  slots = 4'd4; row_bits = w_pw << 1;
      end
      MODE_4BPP: begin
        mode_eff = MODE_4BPP;  slots = 4'd2; row_bits = w_pw << 2;
      end
      MODE_24BPP: begin
        mode_eff = MODE_24BPP; slots = 4'd1; row_bits = (w_pw << 4) + (w_pw << 3);
      end
      default: begin
        mode_eff = MODE_8BPP;  slots = 4'd1; row_bits = w_pw << 3;
      end
    endcase
    packed_len = BW'((row_bits + PW'(7)) >> 3);
    stride_ext = BW'(cfg_i.stride);
    stride_eff = (stride_ext < packed_len) ? packed_len : stride_ext;
  end

  assign acc   = req_i.valid && req_i.ready;
  assign issue = (rem_q != '0) && room_i;
  assign req_i.ready = (rem_q == '0) || ((rem_q == 4'd1) && issue);

  always_comb begin
    w_left = CW'(w_eff) - col_q;
    if (col_q >= CW'(w_eff)) begin
      n_pix = '0;
    end else if (w_left > CW'(slots)) begin
      n_pix = slots;
    end else begin
      n_pix = w_left[3:0];
    end
  end

  // Palette index of the current slot, most significant bits first
  always_comb begin
    case (imode_q)
      MODE_1BPP: slot_idx = {7'd0, dat_q[7]};
      MODE_2BPP: slot_idx = {6'd0, dat_q[7:6]};
      MODE_4BPP: slot_idx = {4'd0, dat_q[7:4]};
      default:   slot_idx = dat_q;
    endcase
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    byte_d  = byte_q;
    phase_d = phase_q;
    part_d  = part_q;
    rem_d   = rem_q;
    ix_d    = ix_q;
    iy_d    = iy_q;
    dat_d   = dat_q;
    imode_d = imode_q;
    dir_d   = dir_q;
    rgb_d   = rgb_q;
    col_inc = '0;
    col_sum = '0;
    byte_nx = byte_q + BW'(1);
    row_nx  = HW'(row_q) + HW'(1);

    if (issue) begin
      rem_d = rem_q - 4'd1;
      ix_d  = ix_q + WW'(1);
      case (imode_q)
        MODE_1BPP: dat_d = {dat_q[6:0], 1'b0};
        MODE_2BPP: dat_d = {dat_q[5:0], 2'b0};
        MODE_4BPP: dat_d = {dat_q[3:0], 4'b0};
        default:   dat_d = dat_q;
      endcase
    end

    if (acc) begin
      case (req_i.req_type)
        REQ_RESTART: begin
          col_d   = '0;
          row_d   = '0;
          byte_d  = '0;
          phase_d = '0;
          part_d  = '0;
        end
        REQ_RASTER: begin
          if (byte_q < packed_len) begin
            if (mode_eff == MODE_24BPP) begin
              case (phase_q)
                2'd0: begin
                  part_d  = {req_i.data_byte, 8'h00};
                  phase_d = 2'd1;
                end
                2'd1: begin
                  part_d  = {part_q[15:8], req_i.data_byte};
                  phase_d = 2'd2;
                end
                default: begin
                  phase_d = 2'd0;
                  col_inc = 4'd1;
                  if (col_q < CW'(w_eff)) begin
                    rem_d = 4'd1;
                    ix_d  = WW'(col_q);
                    iy_d  = row_q;
                    dir_d = 1'b1;
                    rgb_d = {part_q, req_i.data_byte};
                  end
                end
              endcase
            end else begin
              col_inc = slots;
              rem_d   = n_pix;
              ix_d    = WW'(col_q);
              iy_d    = row_q;
              dat_d   = req_i.data_byte;
              imode_d = mode_eff;
              dir_d   = 1'b0;
            end
          end
          // Saturate: any column at or past the width only matters as such
          col_sum = {1'b0, col_q} + (CW + 1)'(col_inc);
          col_d   = col_sum[CW] ? '1 : col_sum[CW-1:0];
          byte_d  = byte_nx;
          if (byte_nx >= stride_eff) begin
            byte_d  = '0;
            col_d   = '0;
            phase_d = '0;
            part_d  = '0;
            row_d   = (row_nx >= h_eff) ? '0 : RW'(row_nx);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      byte_q  <= '0;
      phase_q <= '0;
      part_q  <= '0;
      rem_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      byte_q  <= byte_d;
      phase_q <= phase_d;
      part_q  <= part_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ix_q    <= ix_d;
    iy_q    <= iy_d;
    dat_q   <= dat_d;
    imode_q <= imode_d;
    dir_q   <= dir_d;
    rgb_q   <= rgb_d;
  end

  assign pal_wr_o.en    = acc && (req_i.req_type == REQ_PAL_WRITE);
  assign pal_wr_o.index = req_i.palette_index;
  assign pal_wr_o.color = req_i.palette_color;

  assign iss_o.valid  = issue;
  assign iss_o.idx    = slot_idx;
  assign iss_o.direct = dir_q;
  assign iss_o.rgb    = rgb_q;
  assign iss_o.x      = XY_W'(ix_q);
  assign iss_o.y      = XY_W'(iy_q);
  assign iss_o.last   = (rem_q == 4'd1);
  assign iss_o.done   = (ix_q == (w_eff - WW'(1))) && (HW'(iy_q) == (h_eff - HW'(1)));

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 4'(SLOT_MAX))
    else $error("issuer holds more slots than one byte can carry");

  a_accept_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (rem_q != '0)) |-> (issue && (rem_q == 4'd1)))
    else $error("word taken while issuer still had pending slots");

endmodule

>>> rtl/ppu_ofifo.sv
// Three-entry output queue that decouples pixel issue from the pixel channel.
`timescale 1ns / 1ps
module ppu_ofifo import ppu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pix_t       data_i,
  output logic [1:0] cnt_o,
  ppu_pix_if.source  pix_o
);

  pix_t       mem_q [OFIFO_DEPTH];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  pix_t       head;

  assign pop  = pix_o.valid && pix_o.ready;
  assign head = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == 2'(OFIFO_DEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
    end
    if (pop) begin
      rd_d = (rd_q == 2'(OFIFO_DEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign cnt_o              = cnt_q;
  assign pix_o.valid        = (cnt_q != 2'd0);
  assign pix_o.pixel_x      = head.x;
  assign pix_o.pixel_y      = head.y;
  assign pix_o.red          = head.red;
  assign pix_o.green        = head.green;
  assign pix_o.blue         = head.blue;
  assign pix_o.last_of_item = head.last;
  assign pix_o.image_done   = head.done;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'(OFIFO_DEPTH)))
    else $error("output queue written while full");

endmodule

>>> rtl/packed_pixel_palette_unpack.sv
// Top level: raster byte stream to 24-bit pixels through a palette memory.
// Path: the issuer registers, the palette read stage, then the output queue.
// Throughput: one pixel per cycle while the queue has room, set by the single
//   palette read port; a raster byte holds the issuer until its pixels, up to 8
//   in 1-bit mode, have issued; palette writes, restarts, padding bytes do not.
// Reset: counters and queue clear, registers take reset values; the palette is
//   left undefined until written and has no clearing pass.
`timescale 1ns / 1ps
module packed_pixel_palette_unpack import ppu_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned MAX_HEIGHT    = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppu_req_if.sink   req_i,
  ppu_cfg_if.sink   cfg_i,
  ppu_pix_if.source pix_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  cfg_t    cfg_q, cfg_d;
  pal_wr_t pal_wr;
  iss_t    iss;
  logic    room;
  logic [1:0] fifo_cnt;
  logic [2:0] fifo_level;

  logic               iss_oob;
  logic               pal_wr_ok;
  logic [COLOR_W-1:0] pal_rdata;

  // Read-stage word, held while the palette read is in flight
  logic               b_valid_q;
  logic               b_dir_q;
  logic               b_oob_q;
  logic [COLOR_W-1:0] b_rgb_q;
  logic [XY_W-1:0]    b_x_q;
  logic [XY_W-1:0]    b_y_q;
  logic               b_last_q;
  logic               b_done_q;
  logic [COLOR_W-1:0] b_color;
  pix_t               b_pix;

  // Register writes land in cfg_q on the next clock; always ready
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.idx)
        CFG_DEPTH_MODE: cfg_d.mode   = cfg_i.wdata[CFG_MODE_W-1:0];
        CFG_WIDTH:      cfg_d.width  = cfg_i.wdata[CFG_DIM_W-1:0];
        CFG_HEIGHT:     cfg_d.height = cfg_i.wdata[CFG_DIM_W-1:0];
        CFG_STRIDE:     cfg_d.stride = cfg_i.wdata;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_8BPP;
      cfg_q.width  <= CFG_DIM_W'(1);
      cfg_q.height <= CFG_DIM_W'(1);
      cfg_q.stride <= CFG_STRIDE_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Issue only while the queue can absorb both the word in flight and this one
  assign fifo_level = {1'b0, fifo_cnt} + {2'b0, b_valid_q};
  assign room       = fifo_level < 3'(OFIFO_DEPTH);

  ppu_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cfg_i    (cfg_q),
    .room_i   (room),
    .pal_wr_o (pal_wr),
    .iss_o    (iss)
  );

  // Indices past the palette depth: drop writes, read back black
  assign pal_wr_ok = pal_wr.en && ({1'b0, pal_wr.index} < 9'(PALETTE_DEPTH));
  assign iss_oob   = {1'b0, iss.idx} >= 9'(PALETTE_DEPTH);

  // A palette write is taken in the cycle the previous byte's final read issues;
  // the read returns the old entry, which is the order the stream asks for.
  ppu_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_wr_ok),
    .waddr_i (pal_wr.index[AW-1:0]),
    .wdata_i (pal_wr.color),
    .re_i    (iss.valid && !iss.direct && !iss_oob),
    .raddr_i (iss.idx[AW-1:0]),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= iss.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss.valid) begin
      b_dir_q  <= iss.direct;
      b_oob_q  <= iss_oob;
      b_rgb_q  <= iss.rgb;
      b_x_q    <= iss.x;
      b_y_q    <= iss.y;
      b_last_q <= iss.last;
      b_done_q <= iss.done;
    end
  end

  always_comb begin
    if (b_dir_q) begin
      b_color = b_rgb_q;
    end else if (b_oob_q) begin
      b_color = '0;
    end else begin
      b_color = pal_rdata;
    end
    b_pix.x     = b_x_q;
    b_pix.y     = b_y_q;
    b_pix.red   = b_color[23:16];
    b_pix.green = b_color[15:8];
    b_pix.blue  = b_color[7:0];
    b_pix.last  = b_last_q;
    b_pix.done  = b_done_q;
  end

  ppu_ofifo u_ofifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (b_valid_q),
    .data_i (b_pix),
    .cnt_o  (fifo_cnt),
    .pix_o  (pix_o)
  );

  // The image's final pixel is always the last one its byte produces
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.image_done) |-> pix_o.last_of_item)
    else $error("image end flagged on a pixel that is not last of its word");

endmodule
